### rtl/core/exyz_pkg.sv
// Shared constants and tables for the Euler-angle rotation matrix unit.
// No dependencies.
package exyz_pkg;

  localparam int EXYZ_ANGLE_BITS     = 16;
  localparam int EXYZ_ELEM_FRAC_BITS = 14;
  localparam int EXYZ_OUT_W          = 16;
  localparam int CORDIC_STEPS        = 30;
  localparam int CORDIC_FRAC         = 30;
  localparam int CORDIC_W            = 34;
  localparam int CORDIC_GAIN_INIT    = 652032874;
  localparam int LANE_LAT            = CORDIC_STEPS + 2;
  localparam int MERGE_LAT           = 2;

  // arctan(2^-i) in 2^32 = full turn units
  function automatic logic [31:0] atan_step(input int unsigned i);
    logic [31:0] r;
    case (i)
      0: r = 32'd536870912;
      1: r = 32'd316933406;
      2: r = 32'd167458907;
      3: r = 32'd85004756;
      4: r = 32'd42667331;
      5: r = 32'd21354465;
      6: r = 32'd10679838;
      7: r = 32'd5340245;
      8: r = 32'd2670163;
      9: r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      24: r = 32'd41;
      25: r = 32'd20;
      26: r = 32'd10;
      27: r = 32'd5;
      28: r = 32'd3;
      29: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/exyz_if.sv
// Valid/ready channel interfaces for angle triples and matrix beats.
// Depends on exyz_pkg.
interface exyz_in_if import exyz_pkg::*; ();
  logic                              valid;
  logic                              ready;
  logic signed [EXYZ_ANGLE_BITS-1:0] angle_x;
  logic signed [EXYZ_ANGLE_BITS-1:0] angle_y;
  logic signed [EXYZ_ANGLE_BITS-1:0] angle_z;

  modport source (output valid, angle_x, angle_y, angle_z, input ready);
  modport sink (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

interface exyz_out_if import exyz_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [EXYZ_OUT_W-1:0] r00;
  logic signed [EXYZ_OUT_W-1:0] r01;
  logic signed [EXYZ_OUT_W-1:0] r02;
  logic signed [EXYZ_OUT_W-1:0] r10;
  logic signed [EXYZ_OUT_W-1:0] r11;
  logic signed [EXYZ_OUT_W-1:0] r12;
  logic signed [EXYZ_OUT_W-1:0] r20;
  logic signed [EXYZ_OUT_W-1:0] r21;
  logic signed [EXYZ_OUT_W-1:0] r22;

  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  input ready);
  modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                output ready);
endinterface

### rtl/core/exyz_cordic_lane.sv
// One sine/cosine lane: half-turn fold, pipelined rotation CORDIC, rounding.
// Depends on exyz_pkg.
module exyz_cordic_lane import exyz_pkg::*; #(
  parameter int ELEMENT_FRAC_BITS = EXYZ_ELEM_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic [EXYZ_ANGLE_BITS-1:0]          angle,
  output logic signed [ELEMENT_FRAC_BITS+1:0] sin_o,
  output logic signed [ELEMENT_FRAC_BITS+1:0] cos_o
);

  localparam int EW = ELEMENT_FRAC_BITS + 2;
  localparam int SH = CORDIC_FRAC - ELEMENT_FRAC_BITS;
  localparam logic signed [CORDIC_W-1:0] ONE_C = CORDIC_W'(1) <<< ELEMENT_FRAC_BITS;

  logic signed [CORDIC_W-1:0] x_r [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] y_r [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] z_r [0:CORDIC_STEPS];
  logic                       flip_r [0:CORDIC_STEPS];
  logic                       zero_r [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] x_nxt [0:CORDIC_STEPS-1];
  logic signed [CORDIC_W-1:0] y_nxt [0:CORDIC_STEPS-1];
  logic signed [CORDIC_W-1:0] z_nxt [0:CORDIC_STEPS-1];

  logic [31:0]                a_full;
  logic [31:0]                a_fold;
  logic                       flip;
  logic signed [CORDIC_W-1:0] cos_rnd;
  logic signed [CORDIC_W-1:0] sin_rnd;
  logic signed [CORDIC_W-1:0] cos_sat;
  logic signed [CORDIC_W-1:0] sin_sat;
  logic signed [EW-1:0]       sin_nxt;
  logic signed [EW-1:0]       cos_nxt;

  always_comb begin
    a_full = 32'(angle) << (32 - EXYZ_ANGLE_BITS);
    flip   = (a_full[31:30] == 2'b01) || (a_full[31:30] == 2'b10);
    a_fold = flip ? (a_full ^ 32'h8000_0000) : a_full;
  end

  always_comb begin
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (!z_r[i][CORDIC_W-1]) begin
        x_nxt[i] = x_r[i] - (y_r[i] >>> i);
        y_nxt[i] = y_r[i] + (x_r[i] >>> i);
        z_nxt[i] = z_r[i] - CORDIC_W'(atan_step(i));
      end else begin
        x_nxt[i] = x_r[i] + (y_r[i] >>> i);
        y_nxt[i] = y_r[i] - (x_r[i] >>> i);
        z_nxt[i] = z_r[i] + CORDIC_W'(atan_step(i));
      end
    end
  end

  generate
    if (SH == 0) begin : g_nornd
      assign cos_rnd = x_r[CORDIC_STEPS];
      assign sin_rnd = y_r[CORDIC_STEPS];
    end else begin : g_rnd
      assign cos_rnd = (x_r[CORDIC_STEPS] + signed'(CORDIC_W'(1) <<< (SH - 1))) >>> SH;
      assign sin_rnd = (y_r[CORDIC_STEPS] + signed'(CORDIC_W'(1) <<< (SH - 1))) >>> SH;
    end
  endgenerate

  always_comb begin
    cos_sat = (cos_rnd > ONE_C) ? ONE_C : ((cos_rnd < -ONE_C) ? -ONE_C : cos_rnd);
    sin_sat = (sin_rnd > ONE_C) ? ONE_C : ((sin_rnd < -ONE_C) ? -ONE_C : sin_rnd);
    if (flip_r[CORDIC_STEPS]) begin
      cos_sat = -cos_sat;
      sin_sat = -sin_sat;
    end
    if (zero_r[CORDIC_STEPS]) begin
      cos_sat = ONE_C;
      sin_sat = '0;
    end
    cos_nxt = EW'(cos_sat);
    sin_nxt = EW'(sin_sat);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= CORDIC_W'(CORDIC_GAIN_INIT);
      y_r[0]    <= '0;
      z_r[0]    <= CORDIC_W'(signed'(a_fold));
      flip_r[0] <= flip;
      zero_r[0] <= (a_full == 32'd0);
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        x_r[i+1]    <= x_nxt[i];
        y_r[i+1]    <= y_nxt[i];
        z_r[i+1]    <= z_nxt[i];
        flip_r[i+1] <= flip_r[i];
        zero_r[i+1] <= zero_r[i];
      end
      cos_o <= cos_nxt;
      sin_o <= sin_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_zero_exact: assert property (@(posedge clk) disable iff (!rst_n)
    en && zero_r[CORDIC_STEPS] |=> cos_o == EW'(ONE_C) && sin_o == '0)
    else $error("zero angle lane not exact");
  a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
    en && !$isunknown(cos_sat) |-> cos_sat <= ONE_C && cos_sat >= -ONE_C)
    else $error("cosine out of range");
  a_sin_range: assert property (@(posedge clk) disable iff (!rst_n)
    en && !$isunknown(sin_sat) |-> sin_sat <= ONE_C && sin_sat >= -ONE_C)
    else $error("sine out of range");
`endif

endmodule

### rtl/core/exyz_merge.sv
// Combines the three lanes' sine/cosine into the matrix, two register stages.
// Depends on exyz_pkg.
module exyz_merge import exyz_pkg::*; #(
  parameter int ELEMENT_FRAC_BITS = EXYZ_ELEM_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic signed [ELEMENT_FRAC_BITS+1:0] sx,
  input  logic signed [ELEMENT_FRAC_BITS+1:0] cx,
  input  logic signed [ELEMENT_FRAC_BITS+1:0] sy,
  input  logic signed [ELEMENT_FRAC_BITS+1:0] cy,
  input  logic signed [ELEMENT_FRAC_BITS+1:0] sz,
  input  logic signed [ELEMENT_FRAC_BITS+1:0] cz,
  output logic signed [EXYZ_OUT_W-1:0]        r_o [0:8]
);

  localparam int EW = ELEMENT_FRAC_BITS + 2;
  localparam int PW = 2 * EW + 1;
  localparam logic signed [PW-1:0] ONE_P  = PW'(1) <<< ELEMENT_FRAC_BITS;
  localparam logic signed [PW-1:0] HALF_P = PW'(1) <<< (ELEMENT_FRAC_BITS - 1);

  function automatic logic signed [EW-1:0] rnd(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = (p + HALF_P) >>> ELEMENT_FRAC_BITS;
    if (t > ONE_P) t = ONE_P;
    else if (t < -ONE_P) t = -ONE_P;
    return EW'(t);
  endfunction

  // stage 1
  logic signed [EW-1:0]   a00_r, a02_r, a10_r, a12_r, r7_r, r8_r, r6_r;
  logic signed [EW-1:0]   sx_r, cx_r;
  logic signed [2*EW-1:0] szcx_r, szsx_r, czcx_r, czsx_r;
  // stage 2
  logic signed [EW-1:0]   r_nxt [0:8];
  logic signed [2*EW-1:0] a02sx, a02cx, a12sx, a12cx;

  always_ff @(posedge clk) begin
    if (en) begin
      a00_r  <= rnd(PW'(cz) * PW'(cy));
      a02_r  <= rnd(PW'(cz) * PW'(sy));
      a10_r  <= rnd(PW'(sz) * PW'(cy));
      a12_r  <= rnd(PW'(sz) * PW'(sy));
      r7_r   <= rnd(PW'(cy) * PW'(sx));
      r8_r   <= rnd(PW'(cy) * PW'(cx));
      r6_r   <= -sy;
      sx_r   <= sx;
      cx_r   <= cx;
      szcx_r <= sz * cx;
      szsx_r <= sz * sx;
      czcx_r <= cz * cx;
      czsx_r <= cz * sx;
    end
  end

  always_comb begin
    a02sx    = a02_r * sx_r;
    a02cx    = a02_r * cx_r;
    a12sx    = a12_r * sx_r;
    a12cx    = a12_r * cx_r;
    r_nxt[0] = a00_r;
    r_nxt[1] = rnd(PW'(a02sx) - PW'(szcx_r));
    r_nxt[2] = rnd(PW'(szsx_r) + PW'(a02cx));
    r_nxt[3] = a10_r;
    r_nxt[4] = rnd(PW'(czcx_r) + PW'(a12sx));
    r_nxt[5] = rnd(PW'(a12cx) - PW'(czsx_r));
    r_nxt[6] = r6_r;
    r_nxt[7] = r7_r;
    r_nxt[8] = r8_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        r_o[k] <= EXYZ_OUT_W'(r_nxt[k]);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_r4_range: assert property (@(posedge clk) disable iff (!rst_n)
    en && !$isunknown(r_nxt[4]) |-> r_nxt[4] <= EW'(ONE_P) && r_nxt[4] >= -EW'(ONE_P))
    else $error("r11 out of range");
  a_r6_neg: assert property (@(posedge clk) disable iff (!rst_n)
    en && !$isunknown(sy) |=> r6_r == -$past(sy))
    else $error("r20 not negated sine");
  a_r1_range: assert property (@(posedge clk) disable iff (!rst_n)
    en && !$isunknown(r_nxt[1]) |-> r_nxt[1] <= EW'(ONE_P) && r_nxt[1] >= -EW'(ONE_P))
    else $error("r01 out of range");
`endif

endmodule

### rtl/core/euler_xyz_rotation_matrix_unit.sv
// Pipeline: input beats pass through the CORDIC lanes and then the product/sum
// merge, all registered, and advance only when the output is not stalled.
// Throughput: one angle triple per cycle; the whole pipeline holds while a
// finished matrix waits. Reset (synchronous, rst_n low) clears the valid pipe.
// Depends on exyz_pkg, exyz_if, exyz_cordic_lane, exyz_merge.
module euler_xyz_rotation_matrix_unit import exyz_pkg::*; #(
  parameter int ELEMENT_FRAC_BITS = EXYZ_ELEM_FRAC_BITS
) (
  input logic       clk,
  input logic       rst_n,
  exyz_in_if.sink   in_bus,
  exyz_out_if.source out_bus
);

  localparam int EW  = ELEMENT_FRAC_BITS + 2;
  localparam int LAT = LANE_LAT + MERGE_LAT;

  logic [LAT-1:0]         vld_r;
  logic [LAT-1:0]         vld_nxt;
  logic                   en;
  logic signed [EW-1:0]   sx, cx, sy, cy, sz, cz;
  logic signed [EXYZ_OUT_W-1:0] r_m [0:8];

  assign en           = !vld_r[LAT-1] || out_bus.ready;
  assign in_bus.ready = en;
  assign vld_nxt      = {vld_r[LAT-2:0], in_bus.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  exyz_cordic_lane #(.ELEMENT_FRAC_BITS(ELEMENT_FRAC_BITS)) u_lane_x (
    .clk(clk), .rst_n(rst_n), .en(en), .angle(in_bus.angle_x), .sin_o(sx), .cos_o(cx)
  );
  exyz_cordic_lane #(.ELEMENT_FRAC_BITS(ELEMENT_FRAC_BITS)) u_lane_y (
    .clk(clk), .rst_n(rst_n), .en(en), .angle(in_bus.angle_y), .sin_o(sy), .cos_o(cy)
  );
  exyz_cordic_lane #(.ELEMENT_FRAC_BITS(ELEMENT_FRAC_BITS)) u_lane_z (
    .clk(clk), .rst_n(rst_n), .en(en), .angle(in_bus.angle_z), .sin_o(sz), .cos_o(cz)
  );

  exyz_merge #(.ELEMENT_FRAC_BITS(ELEMENT_FRAC_BITS)) u_merge (
    .clk(clk), .rst_n(rst_n), .en(en),
    .sx(sx), .cx(cx), .sy(sy), .cy(cy), .sz(sz), .cz(cz), .r_o(r_m)
  );

  assign out_bus.valid = vld_r[LAT-1];
  assign out_bus.r00   = r_m[0];
  assign out_bus.r01   = r_m[1];
  assign out_bus.r02   = r_m[2];
  assign out_bus.r10   = r_m[3];
  assign out_bus.r11   = r_m[4];
  assign out_bus.r12   = r_m[5];
  assign out_bus.r20   = r_m[6];
  assign out_bus.r21   = r_m[7];
  assign out_bus.r22   = r_m[8];

`ifndef NO_ASSERTIONS
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_bus.valid)
    else $error("valid after reset");
  a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipe moved while stalled");
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    en |=> vld_r == $past(vld_nxt))
    else $error("pipe did not advance");
`endif

endmodule

### tb/tb_euler_xyz_rotation_matrix_unit.sv
// Testbench for the Euler-angle rotation matrix unit: angle triples in, 3x3 Q1.14
// matrices out, each compared as a whole with the matrix from a local CORDIC predictor.
// Depends on exyz_pkg, exyz_if and euler_xyz_rotation_matrix_unit.
module tb_euler_xyz_rotation_matrix_unit;
  import exyz_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 60;

  typedef struct packed {
    logic [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  } matrix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  exyz_in_if  in_bus ();
  exyz_out_if out_bus ();

  euler_xyz_rotation_matrix_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus.sink),
    .out_bus(out_bus.source)
  );

  always #4 clk = ~clk;

  matrix_t expected_matrices[$];
  int      mismatch_count = 0;
  int      idle_cycles = 0;
  bit      long_hold = 1'b0;
  bit      stall_enable = 1'b0;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp_unit(longint v);
    longint one;
    one = longint'(1) << EXYZ_ELEM_FRAC_BITS;
    if (v > one) return one;
    if (v < -one) return -one;
    return v;
  endfunction

  function automatic longint round_product(longint p);
    return clamp_unit(floor_shift(p + (longint'(1) << (EXYZ_ELEM_FRAC_BITS - 1)),
                                  EXYZ_ELEM_FRAC_BITS));
  endfunction

  function automatic void cordic_sin_cos(logic [15:0] angle, output longint s,
                                         output longint c);
    logic [31:0] a;
    bit          flip;
    longint      x, y, z, nx;
    int          sh;
    a = {angle, 16'h0000};
    flip = 1'b0;
    x = CORDIC_GAIN_INIT;
    y = 0;
    sh = CORDIC_FRAC - EXYZ_ELEM_FRAC_BITS;
    if (a == 32'd0) begin
      s = 0;
      c = longint'(1) << EXYZ_ELEM_FRAC_BITS;
      return;
    end
    if (a[31:30] == 2'b01 || a[31:30] == 2'b10) begin
      a = a - 32'h8000_0000;
      flip = 1'b1;
    end
    z = longint'($signed(a));
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        z = z - longint'(atan_step(i));
      end else begin
        nx = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        z = z + longint'(atan_step(i));
      end
      x = nx;
    end
    c = clamp_unit(floor_shift(x + (longint'(1) << (sh - 1)), sh));
    s = clamp_unit(floor_shift(y + (longint'(1) << (sh - 1)), sh));
    if (flip) begin
      c = -c;
      s = -s;
    end
  endfunction

  function automatic matrix_t rotation_matrix(logic [15:0] ax, logic [15:0] ay,
                                              logic [15:0] az);
    longint  sx, cx, sy, cy, sz, cz, a00, a02, a10, a12;
    matrix_t m;
    cordic_sin_cos(ax, sx, cx);
    cordic_sin_cos(ay, sy, cy);
    cordic_sin_cos(az, sz, cz);
    a00 = round_product(cz * cy);
    a02 = round_product(cz * sy);
    a10 = round_product(sz * cy);
    a12 = round_product(sz * sy);
    m.r00 = a00[15:0];
    m.r01 = 16'(round_product(-sz * cx + a02 * sx));
    m.r02 = 16'(round_product(sz * sx + a02 * cx));
    m.r10 = a10[15:0];
    m.r11 = 16'(round_product(cz * cx + a12 * sx));
    m.r12 = 16'(round_product(-cz * sx + a12 * cx));
    m.r20 = 16'(-sy);
    m.r21 = 16'(round_product(cy * sx));
    m.r22 = 16'(round_product(cy * cx));
    return m;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 60) return 0;
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] random_angle();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7FFF;
      3: return {2'($urandom_range(0, 3)), 14'h0000};
      4: return 16'($urandom_range(0, 7)) - 16'd3;
      default: return 16'($urandom);
    endcase
  endfunction

  // sender side
  bit random_gaps = 1'b0;

  task automatic send_angles(logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
    int gap;
    gap = random_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.angle_x <= ax;
    in_bus.angle_y <= ay;
    in_bus.angle_z <= az;
    do @(posedge clk); while (!in_bus.ready);
    expected_matrices.push_back(rotation_matrix(ax, ay, az));
    @(negedge clk);
  endtask

  task automatic end_stream();
    in_bus.valid <= 1'b0;
  endtask

  // receiver side: stall pattern changes at falling edges
  initial begin
    int stall;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_bus.ready <= 1'b0;
      end else if (stall_enable) begin
        stall = pick_gap();
        if (stall > 0) begin
          out_bus.ready <= 1'b0;
          repeat (stall - 1) @(negedge clk);
        end else begin
          out_bus.ready <= 1'b1;
        end
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    matrix_t got, want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got = {out_bus.r00, out_bus.r01, out_bus.r02, out_bus.r10, out_bus.r11,
             out_bus.r12, out_bus.r20, out_bus.r21, out_bus.r22};
      if (expected_matrices.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected matrix beat %h", got);
      end else begin
        want = expected_matrices.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("matrix mismatch: expected %h actual %h", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic test_directed();
    logic [15:0] corners[8];
    corners = '{16'h0000, 16'h8000, 16'h7FFF, 16'h4000, 16'hC000, 16'h0001,
                16'hFFFF, 16'h2000};
    for (int k = 0; k < 8; k++) send_angles(corners[k], 16'h0000, 16'h0000);
    for (int k = 1; k < 8; k++) send_angles(16'h0000, corners[k], 16'h0000);
    for (int k = 1; k < 8; k++) send_angles(16'h0000, 16'h0000, corners[k]);
    send_angles(16'h8000, 16'h8000, 16'h8000);
    send_angles(16'h5555, 16'hAAAA, 16'h1234);
  endtask

  task automatic test_random_stream();
    random_gaps = 1'b1;
    stall_enable = 1'b1;
    for (int n = 0; n < 1200; n++)
      send_angles(random_angle(), random_angle(), random_angle());
  endtask

  task automatic test_back_pressure();
    random_gaps = 1'b0;
    fork
      begin
        @(negedge clk);
        long_hold = 1'b1;
        repeat (120) @(negedge clk);
        long_hold = 1'b0;
      end
      for (int n = 0; n < 100; n++)
        send_angles(16'($urandom), 16'($urandom), 16'($urandom));
    join
  endtask

  initial begin
    in_bus.valid   = 1'b0;
    in_bus.angle_x = '0;
    in_bus.angle_y = '0;
    in_bus.angle_z = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random_stream();
    test_back_pressure();
    end_stream();
    while (expected_matrices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
